FILE: rtl/core/slcb_pkg.sv
// ----------------------------------------------------------------------------
// slcb_pkg
// Shared types, constants and helpers for the splat layer color blend.
// ----------------------------------------------------------------------------
package slcb_pkg;

  localparam int unsigned MaxLayers = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned ColorW    = 24;
  localparam int unsigned AccW      = 16;
  localparam int unsigned NumW      = 24;
  localparam int unsigned NumChan   = 3;

  // Reciprocal of 255 scaled by 2^31, rounded up; exact for every sum below 2^24
  // that a blend can produce.
  localparam logic [23:0] Recip255 = 24'h808081;
  localparam int unsigned RecipSh  = 31;

  typedef enum logic [CfgIdxW-1:0] {
    RegActiveMask = 3'd0,
    RegColors01   = 3'd1,
    RegColors23   = 3'd2,
    RegColors45   = 3'd3,
    RegColors67   = 3'd4
  } slcb_reg_e;

  typedef struct packed {
    logic [7:0] weight_0;
    logic [7:0] weight_1;
    logic [7:0] weight_2;
    logic [7:0] weight_3;
    logic [7:0] weight_4;
    logic [7:0] weight_5;
    logic [7:0] weight_6;
    logic [7:0] weight_7;
  } slcb_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } slcb_out_t;

  // Item between layer stages; channel 0 is red.
  typedef struct packed {
    logic                              valid;
    logic                              started;
    logic [NumChan-1:0][AccW-1:0]      acc;
    logic [MaxLayers-1:0][7:0]         wts;
  } slcb_tok_t;

  // Item between the product and the divide step of one layer.
  typedef struct packed {
    logic                              valid;
    logic                              started;
    logic                              blend;
    logic [NumChan-1:0][NumW-1:0]      num;
    logic [MaxLayers-1:0][7:0]         wts;
  } slcb_mid_t;

  function automatic logic [AccW-1:0] div255(input logic [NumW-1:0] x);
    logic [47:0] prod;
    prod = {24'd0, x} * {24'd0, Recip255};
    return prod[RecipSh +: AccW];
  endfunction

endpackage

FILE: rtl/core/splat_layer_color_blend.sv
// ----------------------------------------------------------------------------
// splat_layer_color_blend
// Blends configured per-layer colors of one terrain cell by its splat weights.
// ----------------------------------------------------------------------------
//  port group   direction  handshake                payload
//  in           input      in_valid_i/in_stall_o    slcb_in_t  (weight_0..weight_7)
//  out          output     out_valid_o/out_stall_i  slcb_out_t (red, green, blue)
//  cfg          input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled; each layer has
// a product stage and a divide-by-255 stage.
// The whole pipeline holds while a result waits at a stalled output.
// A cell with no active layer runs through and gives no result.
// Reset clears the valid bits and all configuration registers.
module splat_layer_color_blend
  import slcb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slcb_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output slcb_out_t           out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic [7:0]                          active_mask_q;
  logic [MaxLayers/2-1:0][CfgDataW-1:0] colors_q;
  logic                                en;
  slcb_tok_t                           tok [MaxLayers+1];
  logic [7:0][7:0]                     wts_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_mask_q <= '0;
      colors_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegActiveMask: active_mask_q <= cfg_data_i[7:0];
        RegColors01:   colors_q[0]   <= cfg_data_i;
        RegColors23:   colors_q[1]   <= cfg_data_i;
        RegColors45:   colors_q[2]   <= cfg_data_i;
        RegColors67:   colors_q[3]   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold every stage while the output register is stalled
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  assign wts_in = {in_data_i.weight_7, in_data_i.weight_6, in_data_i.weight_5,
                   in_data_i.weight_4, in_data_i.weight_3, in_data_i.weight_2,
                   in_data_i.weight_1, in_data_i.weight_0};

  assign tok[0] = '{valid: in_valid_i, started: 1'b0, acc: '0, wts: wts_in};

  for (genvar g = 0; g < MaxLayers; g++) begin : g_layer
    slcb_stage u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .active_i (active_mask_q[g]),
      .color_i  (colors_q[g/2][(g%2)*ColorW +: ColorW]),
      .weight_i (tok[g].wts[g]),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  assign out_valid_o      = tok[MaxLayers].valid & tok[MaxLayers].started;
  assign out_data_o.red   = tok[MaxLayers].acc[0][15:8];
  assign out_data_o.green = tok[MaxLayers].acc[1][15:8];
  assign out_data_o.blue  = tok[MaxLayers].acc[2][15:8];

endmodule

FILE: rtl/core/slcb_stage.sv
// ----------------------------------------------------------------------------
// slcb_stage
// One layer of the blend: products and sum, then divide by 255; an inactive
// layer passes the sums on and the lowest active layer loads its own color.
module slcb_stage
  import slcb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 active_i,
  input  logic [ColorW-1:0]    color_i,
  input  logic [7:0]           weight_i,
  input  slcb_tok_t            tok_i,
  output slcb_tok_t            tok_o
);

  slcb_mid_t mid_d, mid_q;
  slcb_tok_t tok_d, tok_q;

  always_comb begin
    logic [AccW-1:0] col;
    logic [7:0]      inv;
    mid_d         = '0;
    mid_d.valid   = tok_i.valid;
    mid_d.started = tok_i.started;
    mid_d.wts     = tok_i.wts;
    inv           = 8'd255 - weight_i;
    for (int ch = 0; ch < NumChan; ch++) begin
      col = {color_i[16 - 8*ch +: 8], 8'd0};
      if (!active_i) begin
        mid_d.num[ch] = {8'd0, tok_i.acc[ch]};
      end else if (!tok_i.started) begin
        // lowest active layer sets the start color
        mid_d.num[ch] = {8'd0, col};
      end else begin
        mid_d.num[ch] = NumW'(tok_i.acc[ch] * inv) + NumW'(col * weight_i);
      end
    end
    mid_d.blend = active_i & tok_i.started;
    if (active_i) begin
      mid_d.started = 1'b1;
    end
  end

  always_comb begin
    tok_d         = '0;
    tok_d.valid   = mid_q.valid;
    tok_d.started = mid_q.started;
    tok_d.wts     = mid_q.wts;
    for (int ch = 0; ch < NumChan; ch++) begin
      tok_d.acc[ch] = mid_q.blend ? div255(mid_q.num[ch]) : mid_q.num[ch][AccW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      tok_q <= '0;
    end else if (en_i) begin
      mid_q <= mid_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

FILE: bench/splat_layer_color_blend_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// splat_layer_color_blend_tb
// Self-checking bench for the splat layer color blend. A behavioral blend of
// the active layers predicts the RGB item for every accepted weight item that
// has an active layer. Each produced item is compared against that prediction,
// under random gaps on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module splat_layer_color_blend_tb;
  import slcb_pkg::*;

  localparam int CLK_HALF       = 6;
  localparam int DRAIN_CYCLES   = 2 * MaxLayers + 8;
  localparam int IDLE_LIMIT     = 4000;
  localparam int TIMEOUT_CYCLES = 200_000;
  localparam int PHASE_CELLS    = 116;
  localparam int HOLD_CYCLES    = 120;

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  slcb_in_t            in_data_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  slcb_out_t           out_data_o;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = RegActiveMask;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Bench copy of the configuration
  logic [7:0]          layer_mask;
  logic [CfgDataW-1:0] layer_pairs [4];

  slcb_out_t   expected_px [$];
  int unsigned err_cnt;
  bit          src_gaps;
  bit          sink_gaps;
  int unsigned sink_wait;
  int unsigned sink_hold_req;

  splat_layer_color_blend uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // Blend the active layers of one cell; returns 0 when no layer is active.
  function automatic bit blend_cell(input slcb_in_t cell_wts, output slcb_out_t px);
    logic [7:0]  wt [MaxLayers];
    logic [23:0] rgb;
    int unsigned acc [3];
    int unsigned shade;
    bit          started;
    wt = '{cell_wts.weight_0, cell_wts.weight_1, cell_wts.weight_2, cell_wts.weight_3,
           cell_wts.weight_4, cell_wts.weight_5, cell_wts.weight_6, cell_wts.weight_7};
    started = 1'b0;
    acc = '{0, 0, 0};
    px = '0;
    for (int l = 0; l < MaxLayers; l++) begin
      if (!layer_mask[l]) continue;
      rgb = (l % 2) ? layer_pairs[l / 2][47:24] : layer_pairs[l / 2][23:0];
      for (int ch = 0; ch < 3; ch++) begin
        shade = {rgb[23 - 8 * ch -: 8], 8'd0};
        if (!started) begin
          acc[ch] = shade;
        end else begin
          acc[ch] = (acc[ch] * (255 - wt[l]) + shade * wt[l]) / 255;
        end
      end
      started = 1'b1;
    end
    px.red   = acc[0][15:8];
    px.green = acc[1][15:8];
    px.blue  = acc[2][15:8];
    return started;
  endfunction

  // Record a prediction for every accepted weight item that has an active layer
  always @(posedge clk_i) begin : cell_monitor
    slcb_out_t px;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      if (blend_cell(in_data_i, px)) expected_px = {expected_px, px};
    end
  end

  task automatic check_chan(input string chan, input logic [7:0] want,
                            input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %02h, actual %02h", $time, chan, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : pixel_check
    slcb_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %06h", $time, out_data_o);
        err_cnt++;
      end else begin
        want = expected_px.pop_front();
        check_chan("red", want.red, out_data_o.red);
        check_chan("green", want.green, out_data_o.green);
        check_chan("blue", want.blue, out_data_o.blue);
      end
    end
  end

  // Output side: random hold-off after each item, plus a long hold on request
  always @(posedge clk_i) begin
    if (sink_hold_req != 0) begin
      sink_wait = sink_hold_req;
      sink_hold_req = 0;
    end else if (sink_wait != 0) begin
      sink_wait--;
    end else if (out_valid_o && !out_stall_i) begin
      sink_wait = sink_gaps ? $urandom_range(0, 3) : 0;
    end
    out_stall_i <= (sink_wait != 0);
  end

  task automatic send_cell(input slcb_in_t cell_wts);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cell_wts;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Lower valid, wait for all pending items, then let the pipeline empty
  task automatic wait_idle();
    int unsigned spin;
    in_valid_i <= 1'b0;
    spin = 0;
    while (expected_px.size() != 0 && spin < IDLE_LIMIT) begin
      @(posedge clk_i);
      spin++;
    end
    if (expected_px.size() != 0) begin
      $display("%0t: %0d items missing, expected %06h first, actual none", $time,
               expected_px.size(), expected_px[0]);
      err_cnt++;
      expected_px.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegActiveMask: layer_mask = val[7:0];
      RegColors01:   layer_pairs[0] = val;
      RegColors23:   layer_pairs[1] = val;
      RegColors45:   layer_pairs[2] = val;
      RegColors67:   layer_pairs[3] = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_palette(input logic [CfgDataW-1:0] p01, input logic [CfgDataW-1:0] p23,
                             input logic [CfgDataW-1:0] p45, input logic [CfgDataW-1:0] p67);
    cfg_write(RegColors01, p01);
    cfg_write(RegColors23, p23);
    cfg_write(RegColors45, p45);
    cfg_write(RegColors67, p67);
  endtask

  function automatic logic [7:0] rand_weight();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic slcb_in_t rand_cell();
    return '{rand_weight(), rand_weight(), rand_weight(), rand_weight(),
             rand_weight(), rand_weight(), rand_weight(), rand_weight()};
  endfunction

  function automatic logic [CfgDataW-1:0] rand_pair();
    return CfgDataW'({$urandom, $urandom});
  endfunction

  // After reset nothing is active, so no item may come out
  task automatic test_reset_defaults();
    send_cell({8{8'hFF}});
    send_cell({8{8'h00}});
    send_cell(rand_cell());
    wait_idle();
  endtask

  task automatic test_extreme_palette();
    slcb_in_t cell_wts;
    set_palette({24'h000000, 24'hFFFFFF}, {24'hFF0000, 24'h00FF00},
                {24'h0000FF, 24'h808080}, {24'hFFFFFF, 24'h123456});
    cfg_write(RegActiveMask, 48'hFF);
    send_cell({8{8'h00}});
    send_cell({8{8'hFF}});
    send_cell({8{8'h55}});
    send_cell({8{8'hAA}});
    send_cell({8{8'h01}});
    send_cell({8{8'hFE}});
    cell_wts = '0; cell_wts.weight_1 = 8'hFF;
    send_cell(cell_wts);
    cell_wts = '0; cell_wts.weight_4 = 8'hFF;
    send_cell(cell_wts);
    cell_wts = '0; cell_wts.weight_7 = 8'hFF;
    send_cell(cell_wts);
    wait_idle();
    // lowest layer only: start color, no blend
    cfg_write(RegActiveMask, 48'h01);
    send_cell({8{8'hFF}});
    wait_idle();
    // top layer only
    cfg_write(RegActiveMask, 48'h80);
    send_cell({8{8'h80}});
    wait_idle();
    cfg_write(RegActiveMask, 48'h81);
    cell_wts = '0;
    send_cell(cell_wts);
    cell_wts.weight_7 = 8'h80;
    send_cell(cell_wts);
    cell_wts.weight_7 = 8'hFF;
    send_cell(cell_wts);
    wait_idle();
  endtask

  // Drop bits above the mask width and writes to unused indexes
  task automatic test_register_decode();
    cfg_write(RegActiveMask, 48'hFFFF_FFFF_FF24);
    send_cell({8{8'h9C}});
    send_cell(rand_cell());
    wait_idle();
    for (int idx = int'(RegColors67) + 1; idx < (1 << CfgIdxW); idx++) begin
      cfg_write(CfgIdxW'(idx), '1);
    end
    send_cell({8{8'h9C}});
    send_cell(rand_cell());
    wait_idle();
  endtask

  task automatic test_random_palettes();
    logic [7:0] mask;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       mask = 8'hFF;
        1:       mask = 8'h00;
        2:       mask = 8'h01 << $urandom_range(0, 7);
        default: mask = 8'($urandom);
      endcase
      cfg_write(RegActiveMask, {40'($urandom), mask});
      case (ph)
        3:       set_palette('0, '0, '0, '0);
        4:       set_palette('1, '1, '1, '1);
        default: set_palette(rand_pair(), rand_pair(), rand_pair(), rand_pair());
      endcase
      for (int n = 0; n < PHASE_CELLS; n++) begin
        if (n % 32 == 0) begin
          src_gaps  = (ph != 0) && ($urandom_range(0, 3) != 0);
          sink_gaps = (ph != 0) && ($urandom_range(0, 3) != 0);
        end
        send_cell(rand_cell());
      end
      wait_idle();
    end
  endtask

  // Fill the pipeline against a long output hold, then pause the sender
  task automatic test_backpressure();
    cfg_write(RegActiveMask, 48'hFF);
    set_palette(rand_pair(), rand_pair(), rand_pair(), rand_pair());
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    sink_hold_req = HOLD_CYCLES;
    for (int n = 0; n < 60; n++) send_cell(rand_cell());
    wait_idle();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    for (int n = 0; n < 40; n++) send_cell(rand_cell());
    wait_idle();
  endtask

  initial begin
    err_cnt       = 0;
    src_gaps      = 1'b1;
    sink_gaps     = 1'b1;
    sink_wait     = 0;
    sink_hold_req = 0;
    layer_mask    = '0;
    layer_pairs   = '{default: '0};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extreme_palette();
    test_register_decode();
    test_random_palettes();
    test_backpressure();

    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("simulation failed");
    $finish;
  end

endmodule
